[sv/keypad_scan_debouncer_unit_assert.svh]
// Assertion macros for the keypad scan debouncer.
// Both macros expect clk and rst_n in scope.
`ifndef KEYPAD_SCAN_DEBOUNCER_UNIT_ASSERT_SVH
`define KEYPAD_SCAN_DEBOUNCER_UNIT_ASSERT_SVH

`define KPD_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define KPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/kpd_pkg.sv]
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types, codes and the key character table of the keypad debouncer.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int LINE_W = 4;
  localparam int CODE_W = 8;
  localparam int CHAR_W = 7;
  localparam int TICK_W = 8;

  localparam logic [TICK_W-1:0] TICKS_RESET = 8'd20;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_ERROR  = 2'd1;
  localparam logic [1:0] MODE_SINGLE = 2'd2;

  typedef struct packed {
    logic              none;
    logic              one;
    logic              multi;
    logic [LINE_W-1:0] lines;
  } kpd_lane_t;

  // Row-major ASCII table: row 0 is 1 2 3 A, row 3 is * 0 # D.
  localparam logic [CHAR_W-1:0] KEY_CHARS [16] = '{
    7'h31, 7'h32, 7'h33, 7'h41,
    7'h34, 7'h35, 7'h36, 7'h42,
    7'h37, 7'h38, 7'h39, 7'h43,
    7'h2A, 7'h30, 7'h23, 7'h44
  };

  function automatic logic [2:0] onehot_index(input logic [LINE_W-1:0] v);
    logic [2:0] idx;
    case (v)
      4'b0001: idx = 3'd0;
      4'b0010: idx = 3'd1;
      4'b0100: idx = 3'd2;
      4'b1000: idx = 3'd3;
      default: idx = 3'd4;
    endcase
    return idx;
  endfunction

  function automatic logic [CHAR_W-1:0] key_to_char(input logic [CODE_W-1:0] code);
    logic [2:0] r;
    logic [2:0] c;
    r = onehot_index(code[7:4]);
    c = onehot_index(code[3:0]);
    if (r[2] || c[2]) begin
      return '0;
    end
    return KEY_CHARS[{r[1:0], c[1:0]}];
  endfunction

endpackage

[sv/keypad_scan_debouncer_unit.sv]
// An accepted request that ends a key registers its result in the output register.
// Throughput: one request per cycle; in_stall rises only while a result
// waits in the output register and the sink stalls it.
// Reset is synchronous and active low: mode goes idle, the counter and both
// key registers clear, and the tick threshold ticks_r returns to 20.
// ----------------------------------------------------------------------------
// keypad_scan_debouncer_unit
// Debounces a scanned 4x4 keypad and emits the ASCII character of each key
// once its release has lasted the programmed number of scan ticks.
// ----------------------------------------------------------------------------
`include "keypad_scan_debouncer_unit_assert.svh"

module keypad_scan_debouncer_unit #(
  parameter int ROW_COUNT = 4,
  parameter int COL_COUNT = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [kpd_pkg::LINE_W-1:0]  in_row_lines,
  input  logic [kpd_pkg::LINE_W-1:0]  in_col_lines,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kpd_pkg::CHAR_W-1:0]  out_key_char,
  output logic [kpd_pkg::CODE_W-1:0]  out_key_code,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import kpd_pkg::*;

  kpd_lane_t row_lane;
  kpd_lane_t col_lane;

  logic [TICK_W-1:0] ticks_r;
  logic [1:0]        mode_r, mode_nxt;
  logic [TICK_W-1:0] count_r, count_nxt;
  logic [CODE_W-1:0] held_r, held_nxt;
  logic [CODE_W-1:0] prev_r, prev_nxt;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic [CODE_W-1:0] out_code_r;

  logic              in_acc;
  logic              emit;
  logic [CODE_W-1:0] new_key;
  logic [TICK_W-1:0] tick_base;
  logic [TICK_W-1:0] tick_inc;
  logic              tick_hit;
  logic [TICK_W-1:0] tick_after;
  logic              all_released;
  logic              any_multi;

  kpd_lane_decode #(.LANES(ROW_COUNT)) u_row (.lines(in_row_lines), .lane(row_lane));
  kpd_lane_decode #(.LANES(COL_COUNT)) u_col (.lines(in_col_lines), .lane(col_lane));

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, ticks_r} : 32'd0;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign all_released = row_lane.none && col_lane.none;
  assign any_multi    = row_lane.multi || col_lane.multi;
  assign new_key      = {row_lane.lines, col_lane.lines};

  // A different key in idle restarts the count before it is incremented.
  always_comb begin
    tick_base = count_r;
    if (mode_r != MODE_ERROR && mode_r != MODE_SINGLE && row_lane.one && col_lane.one &&
        new_key != prev_r && prev_r != '0) begin
      tick_base = '0;
    end
  end

  assign tick_inc   = tick_base + 8'd1;
  assign tick_hit   = (tick_inc == ticks_r);
  assign tick_after = tick_hit ? '0 : tick_inc;

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    held_nxt  = held_r;
    prev_nxt  = prev_r;
    emit      = 1'b0;
    case (mode_r)
      MODE_ERROR: begin
        if (all_released) begin
          count_nxt = tick_after;
          if (tick_hit) begin
            mode_nxt = MODE_IDLE;
          end
        end
      end
      MODE_SINGLE: begin
        if (any_multi) begin
          mode_nxt = MODE_ERROR;
        end else if (all_released) begin
          count_nxt = tick_after;
          if (tick_hit) begin
            emit     = 1'b1;
            held_nxt = '0;
            mode_nxt = MODE_IDLE;
          end
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        if (any_multi) begin
          mode_nxt = MODE_ERROR;
        end else if (row_lane.one && col_lane.one) begin
          held_nxt  = new_key;
          prev_nxt  = new_key;
          count_nxt = tick_after;
          if (tick_hit) begin
            mode_nxt = MODE_SINGLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r     <= TICKS_RESET;
      mode_r      <= MODE_IDLE;
      count_r     <= '0;
      held_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == 1'b0) begin
        ticks_r <= pwdata[TICK_W-1:0];
      end
      if (in_acc) begin
        mode_r  <= mode_nxt;
        count_r <= count_nxt;
        held_r  <= held_nxt;
        prev_r  <= prev_nxt;
      end
      if (in_acc && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_char_r <= key_to_char(held_r);
      out_code_r <= held_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_char = out_char_r;
  assign out_key_code = out_code_r;

  `KPD_ASSERT(a_out_code_onehot, !out_valid_r || ($onehot(out_code_r[7:4]) && $onehot(out_code_r[3:0])), "result key code is not one row and one column")
  `KPD_ASSERT(a_single_has_key, mode_r != MODE_SINGLE || held_r != '0, "single mode without a held key")
  `KPD_ASSERT_NEXT(a_emit_to_idle, in_acc && emit, mode_r == MODE_IDLE && held_r == '0 && out_valid_r, "emitted request did not return to idle")

endmodule

[sv/kpd_lane_decode.sv]
// ----------------------------------------------------------------------------
// kpd_lane_decode
// Masks one group of scan lines and classifies it as none, one or several.
// ----------------------------------------------------------------------------
module kpd_lane_decode #(
  parameter int LANES = 4
) (
  input  logic [kpd_pkg::LINE_W-1:0] lines,
  output kpd_pkg::kpd_lane_t         lane
);
  import kpd_pkg::*;

  localparam logic [LINE_W-1:0] MASK = LINE_W'((1 << LANES) - 1);

  logic [LINE_W-1:0] masked;
  logic              several;

  assign masked  = lines & MASK;
  assign several = (masked & (masked - 4'd1)) != '0;

  assign lane.none  = (masked == '0);
  assign lane.multi = several;
  assign lane.one   = (masked != '0) && !several;
  assign lane.lines = masked;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad scan debouncer. A short table of scan
// ticks covers the corner cases, then random keystrokes with bounces,
// partial releases and noise run under several debounce settings. Every
// accepted scan tick goes through a local model of the debouncer, and each
// key result is compared field by field with the oldest expected key.
// ----------------------------------------------------------------------------
module tb_top;
  import kpd_pkg::*;

  localparam int LIMIT = 200000;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [CODE_W-1:0] code;
  } key_event_t;

  typedef struct packed {
    logic [LINE_W-1:0] rows;
    logic [LINE_W-1:0] cols;
    logic [TICK_W-1:0] set_ticks;
    logic              typed;
    logic              hit;
    logic [CHAR_W-1:0] ch;
    logic [CODE_W-1:0] code;
  } scan_row_t;

  // A nonzero set_ticks programs the threshold before the row is sent.
  localparam scan_row_t DIR_TAB [26] = '{
    '{4'h1, 4'h1, 8'd0, 1'b1, 1'b0, 7'h00, 8'h00},
    '{4'h0, 4'h0, 8'd0, 1'b1, 1'b0, 7'h00, 8'h00},
    '{4'h1, 4'h1, 8'd2, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h0, 4'h0, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h0, 4'h0, 8'd0, 1'b1, 1'b1, 7'h31, 8'h11},
    '{4'h8, 4'h8, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h8, 4'h8, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h8, 4'h0, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h0, 4'h0, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h0, 4'h0, 8'd0, 1'b1, 1'b1, 7'h44, 8'h88},
    '{4'h8, 4'h1, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h1, 4'h1, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h1, 4'h1, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h3, 4'h1, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h0, 4'h0, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h1, 4'h0, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h0, 4'h0, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h2, 4'h0, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h0, 4'h4, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h4, 4'h4, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h1, 4'hF, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h0, 4'h0, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h2, 4'h8, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h2, 4'h8, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h0, 4'h0, 8'd0, 1'b0, 1'b0, 7'h00, 8'h00},
    '{4'h0, 4'h0, 8'd0, 1'b1, 1'b1, 7'h42, 8'h28}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [LINE_W-1:0] in_row_lines = '0;
  logic [LINE_W-1:0] in_col_lines = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CHAR_W-1:0] out_key_char;
  logic [CODE_W-1:0] out_key_code;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic              tag_typed = 1'b0;
  logic              tag_hit = 1'b0;
  logic [CHAR_W-1:0] tag_char = '0;
  logic [CODE_W-1:0] tag_code = '0;

  logic [1:0]        kp_mode = MODE_IDLE;
  logic [TICK_W-1:0] kp_count = '0;
  logic [CODE_W-1:0] kp_held = '0;
  logic [CODE_W-1:0] kp_prev = '0;
  logic [TICK_W-1:0] kp_ticks = TICKS_RESET;

  key_event_t        pending_keys [$];
  int                mismatches = 0;
  int                scans_sent = 0;
  int                cycles = 0;
  bit                calm = 1'b0;
  logic [LINE_W-1:0] last_rows = 4'h1;
  logic [LINE_W-1:0] last_cols = 4'h1;

  keypad_scan_debouncer_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_row_lines (in_row_lines),
    .in_col_lines (in_col_lines),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_key_char (out_key_char),
    .out_key_code (out_key_code),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [CHAR_W-1:0] key_ascii(input logic [CODE_W-1:0] code);
    string glyphs;
    byte   g;
    int    ri;
    int    ci;
    glyphs = "123A456B789C*0#D";
    ri = -1;
    ci = -1;
    for (int i = 0; i < 4; i++) begin
      if (code[7:4] == (4'b0001 << i)) ri = i;
      if (code[3:0] == (4'b0001 << i)) ci = i;
    end
    if (ri < 0 || ci < 0) begin
      return '0;
    end
    g = glyphs[ri * 4 + ci];
    return g[6:0];
  endfunction

  function automatic bit count_tick();
    kp_count = kp_count + 8'd1;
    if (kp_count == kp_ticks) begin
      kp_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic scan_step(input logic [LINE_W-1:0] rows, input logic [LINE_W-1:0] cols,
                           output logic hit, output key_event_t ev);
    int                nr;
    int                nc;
    logic [LINE_W-1:0] rb;
    logic [LINE_W-1:0] cb;
    hit = 1'b0;
    ev = '0;
    nr = 0;
    nc = 0;
    rb = '0;
    cb = '0;
    for (int i = 0; i < LINE_W; i++) begin
      if (rows[i]) begin
        nr++;
        rb = 4'b0001 << i;
      end
      if (cols[i]) begin
        nc++;
        cb = 4'b0001 << i;
      end
    end
    case (kp_mode)
      MODE_ERROR: begin
        if (nr == 0 && nc == 0) begin
          if (count_tick()) kp_mode = MODE_IDLE;
        end
      end
      MODE_SINGLE: begin
        if (nr > 1 || nc > 1) begin
          kp_mode = MODE_ERROR;
        end else if (nr == 0 && nc == 0) begin
          if (count_tick()) begin
            hit = 1'b1;
            ev.ch = key_ascii(kp_held);
            ev.code = kp_held;
            kp_held = '0;
            kp_mode = MODE_IDLE;
          end
        end
      end
      default: begin
        kp_mode = MODE_IDLE;
        if (nr > 1 || nc > 1) begin
          kp_mode = MODE_ERROR;
        end else if (nr == 1 && nc == 1) begin
          kp_held = {rb, cb};
          if (kp_held != kp_prev && kp_prev != '0) kp_count = '0;
          kp_prev = kp_held;
          if (count_tick()) kp_mode = MODE_SINGLE;
        end
      end
    endcase
  endtask

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin : monitor
    logic       hit;
    key_event_t ev;
    key_event_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_keys.size() == 0) begin
          flag($sformatf("unexpected key char %h code %h", out_key_char, out_key_code));
        end else begin
          want = pending_keys.pop_front();
          if (out_key_char != want.ch)
            flag($sformatf("key_char expected %h got %h", want.ch, out_key_char));
          if (out_key_code != want.code)
            flag($sformatf("key_code expected %h got %h", want.code, out_key_code));
        end
      end
      if (in_valid && !in_stall) begin
        scan_step(in_row_lines, in_col_lines, hit, ev);
        if (tag_typed) begin
          if (tag_hit) pending_keys.push_back('{tag_char, tag_code});
        end else if (hit) begin
          pending_keys.push_back(ev);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 17);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("keypad_scan_debouncer_unit regression: fail");
      $finish;
    end
  end

  task automatic send_scan(input logic [LINE_W-1:0] rows, input logic [LINE_W-1:0] cols,
                           input logic typed = 1'b0, input logic hit = 1'b0,
                           input logic [CHAR_W-1:0] ch = '0,
                           input logic [CODE_W-1:0] code = '0);
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_row_lines <= rows;
    in_col_lines <= cols;
    tag_typed <= typed;
    tag_hit <= hit;
    tag_char <= ch;
    tag_code <= code;
    do @(posedge clk); while (in_stall);
    scans_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_ticks(input logic [TICK_W-1:0] value);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    kp_ticks = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic keystroke(input int ticks);
    int press_len;
    int rel_len;
    bit noisy;
    noisy = (ticks < 32);
    if ($urandom_range(0, 3) != 0) begin
      last_rows = 4'b0001 << $urandom_range(0, 3);
      last_cols = 4'b0001 << $urandom_range(0, 3);
    end
    if (noisy && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 4))
        send_scan(LINE_W'($urandom_range(0, 15)), LINE_W'($urandom_range(0, 15)));
    end
    press_len = ticks + $urandom_range(0, 2);
    rel_len = ticks + $urandom_range(0, 2);
    repeat (press_len) begin
      if (noisy && $urandom_range(0, 11) == 0)
        send_scan(LINE_W'($urandom_range(0, 15)), LINE_W'($urandom_range(0, 15)));
      else
        send_scan(last_rows, last_cols);
    end
    repeat (rel_len) begin
      if (noisy && $urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 2))
          0: send_scan(last_rows, 4'h0);
          1: send_scan(4'h0, last_cols);
          default: send_scan(LINE_W'($urandom_range(0, 15)),
                             LINE_W'($urandom_range(0, 15)));
        endcase
      end else begin
        send_scan(4'h0, 4'h0);
      end
    end
    if ($urandom_range(0, 39) == 0) wait_drained();
  endtask

  task automatic run_phase(input int ticks, input int budget);
    int start;
    write_ticks(ticks[TICK_W-1:0]);
    start = scans_sent;
    while (scans_sent - start < budget) keystroke(ticks);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].set_ticks != '0) write_ticks(DIR_TAB[i].set_ticks);
      send_scan(DIR_TAB[i].rows, DIR_TAB[i].cols, DIR_TAB[i].typed, DIR_TAB[i].hit,
                DIR_TAB[i].ch, DIR_TAB[i].code);
    end

    run_phase(1, 120);
    run_phase(3, 150);
    calm = 1'b1;
    run_phase(20, 100);
    calm = 1'b0;
    run_phase(255, 500);

    // The count left at the old threshold is above the new one, so the
    // press is only accepted after the counter wraps around.
    repeat (10) send_scan(4'h4, 4'h2);
    write_ticks(8'd3);
    repeat (252) send_scan(4'h4, 4'h2);
    repeat (5) send_scan(4'h0, 4'h0);

    run_phase($urandom_range(2, 7), 100);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("keypad_scan_debouncer_unit regression: pass");
    end else begin
      $display("keypad_scan_debouncer_unit regression: fail");
    end
    $finish;
  end

endmodule
